@@ rtl/lps_pkg.sv @@
// shared constants and codes for the line pixel stepper
`timescale 1ns / 1ps

package lps_pkg;

    // default coordinate width in bits
    localparam int COORD_BITS_DEF = 11;

    // color word width
    localparam int COLOR_BITS = 32;

    // command codes carried by the opcode field
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } lps_op_t;

endpackage

@@ rtl/lps_ifs.sv @@
// valid/ready channel interfaces for commands and pixels
`timescale 1ns / 1ps

interface lps_cmd_if #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;
    logic [lps_pkg::COLOR_BITS-1:0] line_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

interface lps_pix_if #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic [lps_pkg::COLOR_BITS-1:0] pixel_color;
    logic                          last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

@@ rtl/lps_setup.sv @@
// line setup: major axis choice, endpoint ordering and error terms
`timescale 1ns / 1ps

module lps_setup #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  steep,
    output logic [COORD_BITS-1:0] major_pos,
    output logic [COORD_BITS-1:0] minor_pos,
    output logic [COORD_BITS-1:0] major_end,
    output logic [COORD_BITS-1:0] major_span,
    output logic [COORD_BITS:0]   error_inc,
    output logic [COORD_BITS:0]   error_dec,
    output logic                  minor_dir,
    output logic                  active
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] amaj0;
    logic [COORD_BITS-1:0] amaj1;
    logic [COORD_BITS-1:0] amin0;
    logic [COORD_BITS-1:0] amin1;
    logic [COORD_BITS-1:0] min1;
    logic [COORD_BITS-1:0] minor_delta;
    logic                  swap;

    // endpoint distances on both axes
    assign dx    = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    assign dy    = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
    assign steep = dx < dy;

    // map onto major and minor axes
    assign amaj0 = steep ? start_y : start_x;
    assign amaj1 = steep ? end_y   : end_x;
    assign amin0 = steep ? start_x : start_y;
    assign amin1 = steep ? end_x   : end_y;

    // order so the major coordinate rises
    assign swap      = amaj1 < amaj0;
    assign major_pos = swap ? amaj1 : amaj0;
    assign major_end = swap ? amaj0 : amaj1;
    assign minor_pos = swap ? amin1 : amin0;
    assign min1      = swap ? amin0 : amin1;

    // error terms
    assign major_span  = major_end - major_pos;
    assign minor_delta = (min1 >= minor_pos) ? min1 - minor_pos : minor_pos - min1;
    assign error_inc   = {minor_delta, 1'b0};
    assign error_dec   = {major_span, 1'b0};
    assign minor_dir   = min1 > minor_pos;
    assign active      = major_span != '0;

endmodule

@@ rtl/line_pixel_stepper.sv @@
// top level of the bresenham line pixel stepper
//
//  channel | dir | payload                                        | beat
//  cmd     | in  | opcode, start_x/y, end_x/y, line_color          | load or step
//  pixel   | out | pixel_x, pixel_y, pixel_color, last_pixel      | one pixel
//
// one command beat per clock while cmd.ready is high; a step while a line is active gives its pixel
// on the next cycle from the output register
// loads and steps while idle give no pixel
// cmd.ready drops only while a pixel waits and pixel.ready is low
// reset clears the active line flag and the output valid flag
`timescale 1ns / 1ps

module line_pixel_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lps_cmd_if.sink   cmd,
    lps_pix_if.source pixel
);

    localparam int EW = COORD_BITS + 3;

    // line state
    logic                          busy_reg;
    logic                          busy_next;
    logic                          steep_reg;
    logic                          steep_next;
    logic [COORD_BITS-1:0]         major_pos_reg;
    logic [COORD_BITS-1:0]         major_pos_next;
    logic [COORD_BITS-1:0]         minor_pos_reg;
    logic [COORD_BITS-1:0]         minor_pos_next;
    logic [COORD_BITS-1:0]         major_end_reg;
    logic [COORD_BITS-1:0]         major_end_next;
    logic [COORD_BITS-1:0]         major_span_reg;
    logic [COORD_BITS-1:0]         major_span_next;
    logic [EW-1:0]                 error_acc_reg;
    logic [EW-1:0]                 error_acc_next;
    logic [COORD_BITS:0]           error_inc_reg;
    logic [COORD_BITS:0]           error_inc_next;
    logic [COORD_BITS:0]           error_dec_reg;
    logic [COORD_BITS:0]           error_dec_next;
    logic                          minor_dir_reg;
    logic                          minor_dir_next;
    logic [lps_pkg::COLOR_BITS-1:0] color_reg;
    logic [lps_pkg::COLOR_BITS-1:0] color_next;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [COORD_BITS-1:0]         pixel_x_reg;
    logic [COORD_BITS-1:0]         pixel_x_next;
    logic [COORD_BITS-1:0]         pixel_y_reg;
    logic [COORD_BITS-1:0]         pixel_y_next;
    logic [lps_pkg::COLOR_BITS-1:0] pixel_color_reg;
    logic [lps_pkg::COLOR_BITS-1:0] pixel_color_next;
    logic                          last_pixel_reg;
    logic                          last_pixel_next;

    // setup results
    logic                          su_steep;
    logic [COORD_BITS-1:0]         su_major_pos;
    logic [COORD_BITS-1:0]         su_minor_pos;
    logic [COORD_BITS-1:0]         su_major_end;
    logic [COORD_BITS-1:0]         su_major_span;
    logic [COORD_BITS:0]           su_error_inc;
    logic [COORD_BITS:0]           su_error_dec;
    logic                          su_minor_dir;
    logic                          su_active;

    // step datapath
    logic                          cmd_fire;
    logic                          is_load;
    logic                          step_fire;
    logic                          last;
    logic [EW-1:0]                 acc_sum;
    logic                          minor_move;

    lps_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x    (cmd.start_x),
        .start_y    (cmd.start_y),
        .end_x      (cmd.end_x),
        .end_y      (cmd.end_y),
        .steep      (su_steep),
        .major_pos  (su_major_pos),
        .minor_pos  (su_minor_pos),
        .major_end  (su_major_end),
        .major_span (su_major_span),
        .error_inc  (su_error_inc),
        .error_dec  (su_error_dec),
        .minor_dir  (su_minor_dir),
        .active     (su_active)
    );

    // handshake
    assign cmd.ready = !out_valid_reg || pixel.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign is_load   = cmd.opcode == lps_pkg::OP_LOAD;
    assign step_fire = cmd_fire && !is_load && busy_reg;

    // error update and end detect
    assign last       = ({1'b0, major_pos_reg} + (COORD_BITS+1)'(1)) == {1'b0, major_end_reg};
    assign acc_sum    = error_acc_reg + {2'b00, error_inc_reg};
    assign minor_move = $signed(acc_sum) > $signed({3'b000, major_span_reg});

    // next state
    always_comb
    begin
        busy_next        = busy_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_end_next   = major_end_reg;
        major_span_next  = major_span_reg;
        error_acc_next   = error_acc_reg;
        error_inc_next   = error_inc_reg;
        error_dec_next   = error_dec_reg;
        minor_dir_next   = minor_dir_reg;
        color_next       = color_reg;
        out_valid_next   = out_valid_reg && !pixel.ready;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_color_next = pixel_color_reg;
        last_pixel_next  = last_pixel_reg;

        if (cmd_fire && is_load)
        begin
            busy_next       = su_active;
            steep_next      = su_steep;
            major_pos_next  = su_major_pos;
            minor_pos_next  = su_minor_pos;
            major_end_next  = su_major_end;
            major_span_next = su_major_span;
            error_acc_next  = '0;
            error_inc_next  = su_error_inc;
            error_dec_next  = su_error_dec;
            minor_dir_next  = su_minor_dir;
            color_next      = cmd.line_color;
        end
        else if (step_fire)
        begin
            out_valid_next   = 1'b1;
            pixel_x_next     = steep_reg ? minor_pos_reg : major_pos_reg;
            pixel_y_next     = steep_reg ? major_pos_reg : minor_pos_reg;
            pixel_color_next = color_reg;
            last_pixel_next  = last;

            if (minor_move)
            begin
                minor_pos_next = minor_dir_reg ? minor_pos_reg + COORD_BITS'(1)
                                               : minor_pos_reg - COORD_BITS'(1);
                error_acc_next = acc_sum - {2'b00, error_dec_reg};
            end
            else
            begin
                error_acc_next = acc_sum;
            end
            major_pos_next = major_pos_reg + COORD_BITS'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line and pixel payload registers
    always_ff @(posedge clk)
    begin
        steep_reg       <= steep_next;
        major_pos_reg   <= major_pos_next;
        minor_pos_reg   <= minor_pos_next;
        major_end_reg   <= major_end_next;
        major_span_reg  <= major_span_next;
        error_acc_reg   <= error_acc_next;
        error_inc_reg   <= error_inc_next;
        error_dec_reg   <= error_dec_next;
        minor_dir_reg   <= minor_dir_next;
        color_reg       <= color_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        last_pixel_reg  <= last_pixel_next;
    end

    // output drive
    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = pixel_x_reg;
    assign pixel.pixel_y     = pixel_y_reg;
    assign pixel.pixel_color = pixel_color_reg;
    assign pixel.last_pixel  = last_pixel_reg;

`ifndef SYNTHESIS
    // a new pixel only follows a step taken on an active line
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_fire))
        else $error("pixel appeared without an active step");

    // an active line never reaches its end coordinate
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (major_pos_reg < major_end_reg))
        else $error("major position ran past line end");

    // error stays within the span band while a line is active
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (($signed(error_acc_reg) <= $signed({3'b000, major_span_reg}))
                  && (($signed(error_acc_reg) + $signed({3'b000, major_span_reg})) > 0)))
        else $error("error accumulator out of range");

    // the last pixel ends the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && last) |=> !busy_reg)
        else $error("line still active after last pixel");
`endif

endmodule

@@ sim/line_pixel_stepper_tb.sv @@
// self-checking testbench for the bresenham line pixel stepper
`timescale 1ns / 1ps

module line_pixel_stepper_tb;

    localparam int CB = lps_pkg::COORD_BITS_DEF;
    localparam int CMAX = (1 << CB) - 1;

    // one pixel as it leaves the block
    typedef struct packed
    {
        logic [CB-1:0]                  x;
        logic [CB-1:0]                  y;
        logic [lps_pkg::COLOR_BITS-1:0] color;
        logic                           last;
    } pixel_t;

    // line walker state plus the queue of pixels still owed by the block
    class bresenham_scoreboard;
        bit                           busy;
        bit                           steep;
        bit                           minor_up;
        bit [CB-1:0]                  major_pos;
        bit [CB-1:0]                  minor_pos;
        bit [CB-1:0]                  major_end;
        bit [CB-1:0]                  major_span;
        int                           err_acc;
        int                           err_inc;
        int                           err_dec;
        bit [lps_pkg::COLOR_BITS-1:0] color;
        pixel_t                       pending_pixels[$];
        int                           errors;
        int                           loads;
        int                           steps;
        int                           pixels_seen;
        int                           lines_finished;

        function int coord_gap(bit [CB-1:0] a, bit [CB-1:0] b);
            return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        // accepted command beat: update the walker and queue any pixel it owes
        function void note_command(lps_pkg::lps_op_t op, bit [CB-1:0] sx, bit [CB-1:0] sy,
                                   bit [CB-1:0] ex, bit [CB-1:0] ey,
                                   bit [lps_pkg::COLOR_BITS-1:0] color_in);
            bit [CB-1:0] maj0;
            bit [CB-1:0] maj1;
            bit [CB-1:0] min0;
            bit [CB-1:0] min1;
            bit [CB-1:0] tmp;
            bit          at_end;
            pixel_t      pix;
            if (op == lps_pkg::OP_LOAD)
            begin
                loads++;
                steep = coord_gap(ex, sx) < coord_gap(ey, sy);
                if (steep)
                begin
                    maj0 = sy; maj1 = ey; min0 = sx; min1 = ex;
                end
                else
                begin
                    maj0 = sx; maj1 = ex; min0 = sy; min1 = ey;
                end
                // walk so the major coordinate rises
                if (maj1 < maj0)
                begin
                    tmp = maj0; maj0 = maj1; maj1 = tmp;
                    tmp = min0; min0 = min1; min1 = tmp;
                end
                major_pos  = maj0;
                major_end  = maj1;
                minor_pos  = min0;
                major_span = maj1 - maj0;
                err_inc    = 2 * coord_gap(min1, min0);
                err_dec    = 2 * int'(major_span);
                minor_up   = min1 > min0;
                err_acc    = 0;
                color      = color_in;
                busy       = major_span != 0;
                return;
            end
            steps++;
            if (!busy)
                return;
            at_end    = (int'(major_pos) + 1) == int'(major_end);
            pix.x     = steep ? minor_pos : major_pos;
            pix.y     = steep ? major_pos : minor_pos;
            pix.color = color;
            pix.last  = at_end;
            pending_pixels.push_back(pix);
            // error update and minor move
            err_acc += err_inc;
            if (err_acc > int'(major_span))
            begin
                minor_pos = minor_up ? minor_pos + CB'(1) : minor_pos - CB'(1);
                err_acc  -= err_dec;
            end
            major_pos = major_pos + CB'(1);
            if (at_end)
                busy = 1'b0;
        endfunction

        // accepted pixel beat: compare with the oldest owed pixel
        function void check_pixel(pixel_t got);
            pixel_t exp_pix;
            pixels_seen++;
            if (got.last)
                lines_finished++;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%0d",
                         $time, got.x, got.y, got.color, got.last);
                return;
            end
            exp_pix = pending_pixels.pop_front();
            if (got.x !== exp_pix.x)
            begin
                errors++;
                $display("%0t: pixel_x expected %0d actual %0d", $time, exp_pix.x, got.x);
            end
            if (got.y !== exp_pix.y)
            begin
                errors++;
                $display("%0t: pixel_y expected %0d actual %0d", $time, exp_pix.y, got.y);
            end
            if (got.color !== exp_pix.color)
            begin
                errors++;
                $display("%0t: pixel_color expected %h actual %h",
                         $time, exp_pix.color, got.color);
            end
            if (got.last !== exp_pix.last)
            begin
                errors++;
                $display("%0t: last_pixel expected %0d actual %0d",
                         $time, exp_pix.last, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   useful_items;
    int   long_lines;

    bresenham_scoreboard sb = new;

    lps_cmd_if #(.COORD_BITS(CB)) cmd_ch ();
    lps_pix_if #(.COORD_BITS(CB)) pix_ch ();

    line_pixel_stepper #(.COORD_BITS(CB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pixel (pix_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // pixel sink: check accepted beats, stall at random
    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
            sb.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_color,
                            pix_ch.last_pixel});
        pix_ch.ready <= no_gaps || ($urandom_range(99) >= 35);
    end

    // one command beat with random gaps in front of it
    task automatic send_cmd(input lps_pkg::lps_op_t op, input logic [CB-1:0] sx,
                            input logic [CB-1:0] sy,
                            input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                            input logic [lps_pkg::COLOR_BITS-1:0] color_in);
        while (!no_gaps && $urandom_range(99) < 35)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.start_x    <= sx;
        cmd_ch.start_y    <= sy;
        cmd_ch.end_x      <= ex;
        cmd_ch.end_y      <= ey;
        cmd_ch.line_color <= color_in;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        // idle steps do not count toward the item budget
        if (op == lps_pkg::OP_LOAD || sb.busy)
            useful_items++;
        sb.note_command(op, sx, sy, ex, ey, color_in);
    endtask

    // step beats carry random junk in the unused fields
    task automatic step_line(input int n);
        repeat (n)
            send_cmd(lps_pkg::OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom), $urandom);
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 20)
            return CMAX;
        return $urandom_range(CMAX);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > CMAX)
            return CMAX;
        return v;
    endfunction

    // load a line, then walk it fully, past its end, or cut it short
    task automatic random_line();
        int x0;
        int y0;
        int x1;
        int y1;
        int n;
        int r;
        r = $urandom_range(99);
        if (r < 3 && long_lines < 3)
        begin
            // longer line anywhere on the grid, kept short enough for the item budget
            long_lines++;
            x0 = $urandom_range(CMAX); y0 = $urandom_range(CMAX);
            x1 = clamp_coord(x0 + int'($urandom_range(120)) - 60);
            y1 = clamp_coord(y0 + int'($urandom_range(120)) - 60);
        end
        else
        begin
            x0 = pick_coord();
            y0 = pick_coord();
            x1 = clamp_coord(x0 + int'($urandom_range(28)) - 14);
            y1 = clamp_coord(y0 + int'($urandom_range(28)) - 14);
        end
        send_cmd(lps_pkg::OP_LOAD, CB'(x0), CB'(y0), CB'(x1), CB'(y1), $urandom);
        r = $urandom_range(99);
        n = sb.busy ? int'(sb.major_span) : 0;
        if (r >= 87)
            n = $urandom_range(n);
        else if (r >= 75)
            n = n + int'($urandom_range(3, 1));
        step_line(n);
    endtask

    // stimulus
    initial
    begin
        int waited;
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= lps_pkg::OP_LOAD;
        cmd_ch.start_x    <= '0;
        cmd_ch.start_y    <= '0;
        cmd_ch.end_x      <= '0;
        cmd_ch.end_y      <= '0;
        cmd_ch.line_color <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step while idle right after reset
        step_line(1);
        // shallow x-major line rising, one step past its end
        send_cmd(lps_pkg::OP_LOAD, 0, 0, 3, 1, '0);
        step_line(4);
        // steep line given top-down at the far corner
        send_cmd(lps_pkg::OP_LOAD, CB'(CMAX), CB'(CMAX), CB'(CMAX - 2), CB'(CMAX - 7), '1);
        step_line(7);
        // zero-span line gives nothing
        send_cmd(lps_pkg::OP_LOAD, 5, 9, 5, 9, 32'h5a5a_a5a5);
        step_line(1);
        // flat line replaced while busy by a falling diagonal
        send_cmd(lps_pkg::OP_LOAD, CB'(CMAX), 0, CB'(CMAX - 3), 0, 32'ha5a5_5a5a);
        step_line(2);
        send_cmd(lps_pkg::OP_LOAD, 0, CB'(CMAX), 2, CB'(CMAX - 2), 32'h1234_5678);
        step_line(2);

        // random lines with some noise
        while (useful_items < 400)
        begin
            no_gaps = (useful_items >= 180 && useful_items < 260);
            if ($urandom_range(99) < 10)
                send_cmd(lps_pkg::lps_op_t'($urandom_range(1)), CB'($urandom),
                         CB'($urandom), CB'($urandom), CB'($urandom), $urandom);
            else
                random_line();
        end
        no_gaps = 1'b0;
        cmd_ch.valid <= 1'b0;

        // drain
        waited = 0;
        while (sb.pending_pixels.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (sb.pending_pixels.size() != 0)
        begin
            sb.errors += sb.pending_pixels.size();
            $display("%0t: %0d pixels never arrived", $time, sb.pending_pixels.size());
        end

        $display("ran %0d loads and %0d steps, checked %0d pixels over %0d finished lines",
                 sb.loads, sb.steps, sb.pixels_seen, sb.lines_finished);
        $display("lines included steep, flat, reversed, zero-span, cut-short and %0d long ones",
                 long_lines);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
